@@ hw/rtl/blte_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package blte_pkg;

	localparam int unsigned DepthDefault = 256;

	typedef enum logic [3:0] {
		K_PUSH = 4'd0, K_POP = 4'd1, K_FRONT = 4'd2, K_BACK = 4'd3,
		K_READ_AT = 4'd4, K_WRITE_AT = 4'd5, K_REMOVE_AT = 4'd6,
		K_ERASE = 4'd7, K_CLEAR = 4'd8, K_FIND = 4'd9,
		K_REMOVE_FIRST = 4'd10, K_REPLACE_FIRST = 4'd11,
		K_REMOVE_ALL = 4'd12, K_REPLACE_ALL = 4'd13
	} kind_t;

	typedef enum logic [2:0] {
		E_OK = 3'd0, E_EMPTY = 3'd1, E_RANGE = 3'd2, E_FULL = 3'd3,
		E_ABSENT = 3'd4, E_KIND = 3'd5
	} err_t;

endpackage
`default_nettype wire

@@ hw/rtl/blte_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
module blte_mem #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/bounded_list_table_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Push, pop, write_at, clear and every request rejected at acceptance give their result in
// the cycle after acceptance; a successful front, back or read_at passes through RD and CHK.
// A walk over the table (search, replacement, removal, erase) passes through S_DONE, RD and
// CHK per entry visited, then S_DONE again. Each visited entry needs a read, a wait for the
// registered read data and a check. One request is in flight; the next is taken after out_ready.
// Reset clears the count and the control state; the table holds no reset value.
module bounded_list_table_engine #(
	parameter int unsigned DEPTH = blte_pkg::DepthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  kind,
	input  wire logic [7:0]  position,
	input  wire logic [8:0]  position_end,
	input  wire logic [31:0] value,
	input  wire logic [31:0] new_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      read_data,
	output logic             found,
	output logic [7:0]       found_index,
	output logic [8:0]       count,
	output logic [2:0]       error
);
	import blte_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	// Width in which positions and the count are compared without losing bits.
	localparam int unsigned XW = (CW > 9) ? CW : 9;

	// One-hot sequencer. A walk reads an entry (RD), then acts on the registered
	// read data (CHK); the read pointer is the shared counter.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_CHK  = 5'b00100,
		S_DONE = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t       state_q;
	kind_t        kind_q;
	logic [31:0]  val_q, nval_q;
	logic [CW-1:0] cnt_q;	// entry count
	logic [CW-1:0] rp_q;	// read pointer of the walk
	logic [CW-1:0] wp_q;	// write pointer for compaction
	logic [CW-1:0] lim_q;	// walk end
	logic [CW-1:0] gap_q;
	logic          hit_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   rd_q;
	err_t          err_q;
	logic          rdsel_q;	// latch memory data as read_data in CHK

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, mem_rdata;

	blte_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	logic [XW-1:0] pos_x, pend_x, cnt_x;
	assign pos_x  = XW'(position);
	assign pend_x = XW'(position_end);
	assign cnt_x  = XW'(cnt_q);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign mem_raddr = rp_q[AW-1:0];

	logic eq;
	assign eq = (mem_rdata == val_q);

	// Decode of a new request: where the sequencer goes and how the walk is set up.
	state_t        acc_state;
	err_t          acc_err;
	logic [CW-1:0] acc_cnt, acc_rp, acc_wp, acc_gap;
	logic          acc_rdsel;

	always_comb begin
		acc_state = S_OUT;
		acc_err   = E_OK;
		acc_cnt   = cnt_q;
		acc_rp    = '0;
		acc_wp    = '0;
		acc_gap   = '0;
		acc_rdsel = 1'b0;
		unique case (kind)
			K_PUSH: begin
				if (cnt_q >= CW'(DEPTH)) acc_err = E_FULL;
				else acc_cnt = cnt_q + 1'b1;
			end
			K_POP: begin
				if (cnt_q == '0) acc_err = E_EMPTY;
				else acc_cnt = cnt_q - 1'b1;
			end
			K_FRONT, K_BACK: begin
				if (cnt_q == '0) begin
					acc_err = E_EMPTY;
				end else begin
					acc_rp    = (kind == K_FRONT) ? '0 : cnt_q - 1'b1;
					acc_rdsel = 1'b1;
					acc_state = S_RD;
				end
			end
			K_READ_AT: begin
				if (pos_x >= cnt_x) begin
					acc_err = E_RANGE;
				end else begin
					acc_rp    = CW'(pos_x);
					acc_rdsel = 1'b1;
					acc_state = S_RD;
				end
			end
			K_WRITE_AT: begin
				if (pos_x >= cnt_x) acc_err = E_RANGE;
			end
			K_REMOVE_AT: begin
				if (pos_x >= cnt_x) begin
					acc_err = E_RANGE;
				end else begin
					acc_wp    = CW'(pos_x);
					acc_rp    = CW'(pos_x) + 1'b1;
					acc_gap   = CW'(1);
					acc_state = S_DONE;
				end
			end
			K_ERASE: begin
				if (pos_x > pend_x || pend_x > cnt_x) begin
					acc_err = E_RANGE;
				end else begin
					acc_wp    = CW'(pos_x);
					acc_rp    = CW'(pend_x);
					acc_gap   = CW'(pend_x - pos_x);
					acc_state = S_DONE;
				end
			end
			K_CLEAR: begin
				acc_cnt = '0;
			end
			K_FIND, K_REMOVE_FIRST, K_REPLACE_FIRST, K_REMOVE_ALL,
			K_REPLACE_ALL: begin
				if (cnt_q == '0) acc_err = E_EMPTY;
				else acc_state = S_DONE;
			end
			default: begin
				acc_err = E_KIND;
			end
		endcase
	end

	// Write port decode: idle writes for push/write_at, walk writes otherwise.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wp_q[AW-1:0];
		mem_wdata = mem_rdata;
		if (state_q == S_IDLE && in_valid) begin
			mem_waddr = cnt_q[AW-1:0];
			mem_wdata = value;
			if (kind == K_PUSH && cnt_q < CW'(DEPTH)) begin
				mem_we = 1'b1;
			end else if (kind == K_WRITE_AT && pos_x < cnt_x) begin
				mem_we    = 1'b1;
				mem_waddr = pos_x[AW-1:0];
			end
		end else if (state_q == S_CHK) begin
			priority case (1'b1)
				(kind_q == K_REMOVE_AT || kind_q == K_ERASE): begin
					mem_we = 1'b1;
				end
				(kind_q == K_REMOVE_FIRST): begin
					mem_we = hit_q;
				end
				(kind_q == K_REMOVE_ALL): begin
					mem_we = hit_q && !eq;
				end
				(kind_q == K_REPLACE_FIRST): begin
					mem_we    = !hit_q && eq;
					mem_waddr = rp_q[AW-1:0];
					mem_wdata = nval_q;
				end
				(kind_q == K_REPLACE_ALL): begin
					mem_we    = eq;
					mem_waddr = rp_q[AW-1:0];
					mem_wdata = nval_q;
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			kind_q  <= K_PUSH;
			val_q   <= '0;
			nval_q  <= '0;
			hit_q   <= 1'b0;
			idx_q   <= '0;
			rd_q    <= '0;
			err_q   <= E_OK;
			rdsel_q <= 1'b0;
			rp_q    <= '0;
			wp_q    <= '0;
			lim_q   <= '0;
			gap_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind_t'(kind);
						val_q   <= value;
						nval_q  <= new_value;
						hit_q   <= 1'b0;
						idx_q   <= '0;
						rd_q    <= '0;
						err_q   <= acc_err;
						rdsel_q <= acc_rdsel;
						rp_q    <= acc_rp;
						wp_q    <= acc_wp;
						lim_q   <= cnt_q;
						gap_q   <= acc_gap;
						cnt_q   <= acc_cnt;
						state_q <= acc_state;
					end
				end
				S_DONE: begin
					// Walk head: stop once the pointer reaches the limit.
					if (rp_q >= lim_q) begin
						unique case (kind_q)
							K_REMOVE_AT, K_ERASE: cnt_q <= cnt_q - gap_q;
							K_REMOVE_FIRST: if (hit_q) cnt_q <= cnt_q - 1'b1;
							K_REMOVE_ALL: if (hit_q) cnt_q <= wp_q;
							default: ;
						endcase
						if (!hit_q && kind_q != K_REMOVE_AT && kind_q != K_ERASE)
							err_q <= E_ABSENT;
						state_q <= S_OUT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (rdsel_q) begin
						rd_q    <= mem_rdata;
						state_q <= S_OUT;
					end else begin
						state_q <= S_DONE;
						priority case (1'b1)
							(kind_q == K_REMOVE_AT || kind_q == K_ERASE): begin
								wp_q <= wp_q + 1'b1;
								rp_q <= rp_q + 1'b1;
							end
							(!hit_q && eq): begin
								hit_q <= 1'b1;
								idx_q <= rp_q;
								wp_q  <= rp_q;
								// A plain find or a single replacement ends at the first match.
								if (kind_q == K_FIND || kind_q == K_REPLACE_FIRST)
									rp_q <= lim_q;
								else
									rp_q <= rp_q + 1'b1;
							end
							(hit_q && kind_q == K_REMOVE_FIRST): begin
								wp_q <= wp_q + 1'b1;
								rp_q <= rp_q + 1'b1;
							end
							(hit_q && kind_q == K_REMOVE_ALL && !eq): begin
								wp_q <= wp_q + 1'b1;
								rp_q <= rp_q + 1'b1;
							end
							default: begin
								rp_q <= rp_q + 1'b1;
							end
						endcase
					end
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign read_data   = rd_q;
	assign found       = hit_q;
	assign found_index = 8'(idx_q);
	assign count       = 9'(cnt_q);
	assign error       = err_q;
endmodule
`default_nettype wire

@@ hw/rtl/blte_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module blte_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       found,
	input wire logic [7:0] found_index,
	input wire logic [8:0] count,
	input wire logic [2:0] error
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(count) && $stable(error))
		else $error("result changed while stalled");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> error == 3'd0) else $error("found with error");
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> found_index == 8'd0) else $error("stray index");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid) else $error("request withdrawn");
endmodule

bind bounded_list_table_engine blte_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .found(found),
	.found_index(found_index), .count(count), .error(error)
);
`default_nettype wire
